@@ hdl/distance_vector_route_table_macros.svh @@
// Assertion macros for the route table
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
// implication checked every clock outside reset
`define DVRT_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define DVRT_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ hdl/dvrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;
  localparam int RouteDepthDef = 64;
  localparam int NbDepthDef = 16;

  localparam logic [1:0] CmdAddNb = 2'd0;
  localparam logic [1:0] CmdVector = 2'd1;
  localparam logic [1:0] CmdTick = 2'd2;
  localparam logic [1:0] CmdDump = 2'd3;

  localparam logic [3:0] StNbAdded = 4'd0;
  localparam logic [3:0] StNbFull = 4'd1;
  localparam logic [3:0] StSelf = 4'd2;
  localparam logic [3:0] StInsert = 4'd3;
  localparam logic [3:0] StImprove = 4'd4;
  localparam logic [3:0] StSameHop = 4'd5;
  localparam logic [3:0] StUnreach = 4'd6;
  localparam logic [3:0] StUnchanged = 4'd7;
  localparam logic [3:0] StUnknown = 4'd8;
  localparam logic [3:0] StFull = 4'd9;
  localparam logic [3:0] StDisabled = 4'd10;
  localparam logic [3:0] StTick = 4'd11;
  localparam logic [3:0] StDump = 4'd12;

  localparam logic [1:0] RegSelf = 2'd0;
  localparam logic [1:0] RegLimit = 2'd1;
  localparam logic [1:0] RegTicks = 2'd2;
  localparam logic [1:0] RegEnable = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  src_id;
    logic [7:0]  dest_id;
    logic [15:0] value;
    logic        eom;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  dest;
    logic [15:0] distance;
    logic [7:0]  hop;
    logic        reach;
    logic [4:0]  down;
    logic        done;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0]  self_id;
    logic [15:0] limit;
    logic [15:0] max_ticks;
    logic        enabled;
  } cfg_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction
endpackage

@@ hdl/dvrt_front.sv @@
// ----------------------------------------------------------------------------
// dvrt_front
// Two-entry command queue toward the engine.
// ----------------------------------------------------------------------------
module dvrt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dvrt_pkg::item_t in_item_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output dvrt_pkg::item_t q_item_o
);
  import dvrt_pkg::*;

  item_t     mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
endmodule

@@ hdl/dvrt_engine.sv @@
// ----------------------------------------------------------------------------
// dvrt_engine
// Sequencer that searches and updates the route and neighbor tables.
// ----------------------------------------------------------------------------
`include "distance_vector_route_table_macros.svh"
module dvrt_engine #(
  parameter int RouteDepth = dvrt_pkg::RouteDepthDef,
  parameter int NbDepth = dvrt_pkg::NbDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dvrt_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  dvrt_pkg::item_t  q_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dvrt_pkg::result_t out_res_o
);
  import dvrt_pkg::*;

  localparam int RW = $clog2(RouteDepth);
  localparam int NW = (NbDepth > 1) ? $clog2(NbDepth) : 1;
  localparam int RCW = $clog2(RouteDepth + 1);
  localparam int NCW = $clog2(NbDepth + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_NBSCAN, S_RTSCAN, S_RTREAD, S_RTJUDGE, S_TICKNB, S_TICKRT,
    S_TICKCHK, S_DUMPRD, S_DUMPCHK, S_OUT
  } state_e;

  state_e state_q;
  item_t  it_q;
  result_t res_q;
  logic   out_valid_q;
  logic [RCW-1:0] route_count_q;
  logic [NCW-1:0] nb_count_q;
  logic [RCW-1:0] ri_q;
  logic [RCW-1:0] la_q;
  logic [NCW-1:0] ni_q;
  logic [15:0]    dist_q;
  logic [15:0]    poison_q;
  logic [4:0]     downs_q;

  logic [7:0]  r_dest [RouteDepth];
  logic [15:0] r_dist [RouteDepth];
  logic [7:0]  r_hop  [RouteDepth];
  logic [RouteDepth-1:0] r_reach_q;

  logic [7:0]  rd_dest_q, rd_hop_q;
  logic [15:0] rd_dist_q;
  logic        rd_zero_q;

  logic [7:0]  nb_id   [NbDepth];
  logic [15:0] nb_cost [NbDepth];
  logic [15:0] nb_age_q [NbDepth];
  logic [NbDepth-1:0] nb_heard_q, nb_down_q;

  logic [7:0]  rd_dest, rd_hop;
  logic [15:0] rd_dist;
  logic [RW-1:0] ri;
  logic [RW-1:0] la;
  logic [NW-1:0] ni;
  logic [15:0] age_inc;

  assign ri = ri_q[RW-1:0];
  assign la = la_q[RW-1:0];
  assign ni = ni_q[NW-1:0];
  assign q_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o = res_q;
  assign age_inc = (nb_age_q[ni] == 16'hFFFF) ? nb_age_q[ni] : nb_age_q[ni] + 16'd1;

  // route data is registered from ri_q and valid in the cycle after ri_q settles; entry 0 follows self_id
  always_comb begin
    if (rd_zero_q) begin
      rd_dest = cfg_i.self_id;
      rd_dist = 16'd0;
      rd_hop = cfg_i.self_id;
    end else begin
      rd_dest = rd_dest_q;
      rd_dist = rd_dist_q;
      rd_hop = rd_hop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      route_count_q <= RCW'(1);
      nb_count_q <= '0;
      r_reach_q <= RouteDepth'(1);
      nb_heard_q <= '0;
      nb_down_q <= '0;
      for (int k = 0; k < NbDepth; k++) nb_age_q[k] <= 16'd0;
      ri_q <= '0;
      la_q <= '0;
      ni_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            it_q <= q_item_i;
            ri_q <= '0;
            ni_q <= '0;
            downs_q <= 5'd0;
            poison_q <= sat_add16(cfg_i.limit, 16'd16);
            res_q <= '{status: StDisabled,
                       dest: (q_item_i.cmd == CmdDump) ? 8'd0 : q_item_i.dest_id,
                       distance: 16'd0, hop: 8'd0, reach: 1'b0, down: 5'd0,
                       done: (q_item_i.cmd == CmdVector) ? q_item_i.eom : 1'b0,
                       last: 1'b1};
            case (q_item_i.cmd)
              CmdAddNb, CmdVector: begin
                if (q_item_i.cmd == CmdVector && !cfg_i.enabled) begin
                  state_q <= S_OUT;
                  out_valid_q <= 1'b1;
                end else state_q <= S_NBSCAN;
              end
              CmdTick: state_q <= S_TICKNB;
              CmdDump: begin
                if (!cfg_i.enabled) begin
                  state_q <= S_OUT;
                  out_valid_q <= 1'b1;
                end else state_q <= S_DUMPRD;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_NBSCAN: begin
          if (ni_q >= nb_count_q ||
              (ni_q < nb_count_q && nb_id[ni] == it_q.src_id)) begin
            if (it_q.cmd == CmdAddNb) begin
              res_q.dest <= it_q.src_id;
              res_q.hop <= it_q.src_id;
              res_q.distance <= it_q.value;
              if (ni_q < nb_count_q) begin
                res_q.status <= StNbAdded;
              end else if (nb_count_q >= NCW'(NbDepth)) begin
                res_q.status <= StNbFull;
              end else begin
                res_q.status <= StNbAdded;
                nb_heard_q[ni] <= 1'b0;
                nb_down_q[ni] <= 1'b0;
                nb_age_q[ni] <= 16'd0;
                nb_count_q <= nb_count_q + NCW'(1);
              end
              state_q <= S_OUT;
              out_valid_q <= 1'b1;
            end else if (ni_q >= nb_count_q) begin
              res_q.status <= StUnknown;
              state_q <= S_OUT;
              out_valid_q <= 1'b1;
            end else begin
              nb_heard_q[ni] <= 1'b1;
              nb_down_q[ni] <= 1'b0;
              nb_age_q[ni] <= 16'd0;
              dist_q <= sat_add16(it_q.value, nb_cost[ni]);
              if (it_q.dest_id == cfg_i.self_id) begin
                res_q.status <= StSelf;
                res_q.dest <= cfg_i.self_id;
                res_q.hop <= cfg_i.self_id;
                res_q.reach <= 1'b1;
                state_q <= S_OUT;
                out_valid_q <= 1'b1;
              end else state_q <= S_RTSCAN;
            end
          end else ni_q <= ni_q + NCW'(1);
        end
        S_RTSCAN: begin
          if (ri_q >= route_count_q) begin
            if (route_count_q >= RCW'(RouteDepth)) begin
              res_q.status <= StFull;
            end else begin
              res_q.status <= StInsert;
              res_q.distance <= dist_q;
              res_q.hop <= it_q.src_id;
              res_q.reach <= 1'b1;
              r_reach_q[ri] <= 1'b1;
              route_count_q <= route_count_q + RCW'(1);
            end
            state_q <= S_OUT;
            out_valid_q <= 1'b1;
          end else state_q <= S_RTREAD;
        end
        S_RTREAD: begin
          if (rd_dest == it_q.dest_id) begin
            state_q <= S_RTJUDGE;
          end else begin
            ri_q <= ri_q + RCW'(1);
            state_q <= S_RTSCAN;
          end
        end
        S_RTJUDGE: begin
          res_q.dest <= rd_dest;
          if (rd_dist > dist_q) begin
            res_q.status <= StImprove;
            res_q.distance <= dist_q;
            res_q.hop <= it_q.src_id;
            res_q.reach <= 1'b1;
            r_reach_q[ri] <= 1'b1;
          end else if (rd_hop == it_q.src_id && rd_dist != dist_q) begin
            res_q.distance <= dist_q;
            res_q.hop <= rd_hop;
            if (dist_q >= cfg_i.limit) begin
              res_q.status <= StUnreach;
              res_q.reach <= 1'b0;
              r_reach_q[ri] <= 1'b0;
            end else begin
              res_q.status <= StSameHop;
              res_q.reach <= r_reach_q[ri];
            end
          end else begin
            res_q.status <= StUnchanged;
            res_q.distance <= rd_dist;
            res_q.hop <= rd_hop;
            res_q.reach <= r_reach_q[ri];
          end
          state_q <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_TICKNB: begin
          if (ni_q >= nb_count_q) begin
            res_q.status <= StTick;
            res_q.dest <= 8'd0;
            res_q.down <= downs_q;
            state_q <= S_OUT;
            out_valid_q <= 1'b1;
          end else if (nb_heard_q[ni] && !nb_down_q[ni]) begin
            nb_age_q[ni] <= age_inc;
            if (age_inc > cfg_i.max_ticks) begin
              nb_down_q[ni] <= 1'b1;
              if (downs_q != 5'd31) downs_q <= downs_q + 5'd1;
              ri_q <= RCW'(1);
              state_q <= S_TICKRT;
            end else ni_q <= ni_q + NCW'(1);
          end else ni_q <= ni_q + NCW'(1);
        end
        S_TICKRT: begin
          if (ri_q >= route_count_q) begin
            ni_q <= ni_q + NCW'(1);
            state_q <= S_TICKNB;
          end else state_q <= S_TICKCHK;
        end
        S_TICKCHK: begin
          ri_q <= ri_q + RCW'(1);
          state_q <= S_TICKRT;
        end
        S_DUMPRD: begin
          if (ri_q >= route_count_q) begin
            state_q <= S_IDLE;
          end else if (r_reach_q[ri]) begin
            la_q <= ri_q + RCW'(1);
            state_q <= S_DUMPCHK;
          end else ri_q <= ri_q + RCW'(1);
        end
        S_DUMPCHK: begin
          // look ahead for another reachable entry to set last
          res_q.status <= StDump;
          res_q.dest <= rd_dest;
          res_q.distance <= rd_dist;
          res_q.hop <= rd_hop;
          res_q.reach <= 1'b1;
          if (la_q >= route_count_q) begin
            res_q.last <= 1'b1;
            out_valid_q <= 1'b1;
            state_q <= S_OUT;
          end else if (r_reach_q[la]) begin
            res_q.last <= 1'b0;
            out_valid_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            res_q.last <= 1'b0;
            la_q <= la_q + RCW'(1);
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (res_q.status == StDump && !res_q.last) begin
              ri_q <= la_q;
              state_q <= S_DUMPRD;
            end else state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_dest_q <= r_dest[ri];
    rd_dist_q <= r_dist[ri];
    rd_hop_q <= r_hop[ri];
    rd_zero_q <= (ri == '0);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_NBSCAN && it_q.cmd == CmdAddNb) begin
      if (ni_q < nb_count_q && nb_id[ni] == it_q.src_id) nb_cost[ni] <= it_q.value;
      else if (ni_q >= nb_count_q && nb_count_q < NCW'(NbDepth)) begin
        nb_id[ni] <= it_q.src_id;
        nb_cost[ni] <= it_q.value;
      end
    end
    if (state_q == S_RTSCAN && ri_q >= route_count_q && route_count_q < RCW'(RouteDepth)) begin
      r_dest[ri] <= it_q.dest_id;
      r_dist[ri] <= dist_q;
      r_hop[ri] <= it_q.src_id;
    end
    if (state_q == S_RTJUDGE) begin
      if (rd_dist > dist_q) begin
        r_dist[ri] <= dist_q;
        r_hop[ri] <= it_q.src_id;
      end else if (rd_hop == it_q.src_id && rd_dist != dist_q) r_dist[ri] <= dist_q;
    end
    if (state_q == S_TICKCHK && rd_hop == nb_id[ni])
      r_dist[ri] <= poison_q;
  end

  `DVRT_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, q_ready_o, !out_valid_o)
  `DVRT_ASSERT_IMP(a_count_pos, clk_i, rst_ni, 1'b1, route_count_q != '0)
  `DVRT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_res_o))
endmodule

@@ hdl/dvrt_regs.sv @@
// ----------------------------------------------------------------------------
// dvrt_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module dvrt_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output dvrt_pkg::cfg_t cfg_o
);
  import dvrt_pkg::*;
  cfg_t cfg_q;
  logic wr;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.self_id <= 8'd0;
      cfg_q.limit <= 16'd256;
      cfg_q.max_ticks <= 16'd1000;
      cfg_q.enabled <= 1'b1;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegSelf: cfg_q.self_id <= pwdata[7:0];
        RegLimit: cfg_q.limit <= pwdata[15:0];
        RegTicks: cfg_q.max_ticks <= pwdata[15:0];
        RegEnable: cfg_q.enabled <= pwdata[0];
        default: cfg_q.enabled <= cfg_q.enabled;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSelf: prdata = {24'd0, cfg_q.self_id};
      RegLimit: prdata = {16'd0, cfg_q.limit};
      RegTicks: prdata = {16'd0, cfg_q.max_ticks};
      RegEnable: prdata = {31'd0, cfg_q.enabled};
      default: prdata = 32'd0;
    endcase
  end
endmodule

@@ hdl/distance_vector_route_table.sv @@
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route table with neighbor aging; front queue feeds a table sequencer.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid_i/ready_o | cmd, src_id, dest_id, value, end_of_message
// out     | out_valid_o/ready_i| status .. last
// cfg     | APB psel/penable   | paddr, pwdata, prdata
// Vector entry: scans the neighbor table, then the route table (registered table reads).
// Tick: scans the neighbors, plus the routes for each neighbor declared down.
// Dump: walks the route table and emits each reachable route; output stalls hold the walk.
// Reset leaves only the self entry; no clearing pass.
// Output stall holds the sequencer; the front queue keeps taking two beats.
module distance_vector_route_table #(
  parameter int RouteDepth = dvrt_pkg::RouteDepthDef,
  parameter int NbDepth = dvrt_pkg::NbDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  src_id_i,
  input  logic [7:0]  dest_id_i,
  input  logic [15:0] value_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [7:0]  dest_id_res_o,
  output logic [15:0] distance_o,
  output logic [7:0]  next_hop_o,
  output logic        reachable_o,
  output logic [4:0]  down_count_o,
  output logic        message_done_o,
  output logic        last_o
);
  import dvrt_pkg::*;
  cfg_t cfg;
  item_t in_item, q_item;
  result_t res;
  logic q_valid, q_ready;

  assign in_item = '{cmd: cmd_i, src_id: src_id_i, dest_id: dest_id_i,
                     value: value_i, eom: end_of_message_i};

  dvrt_regs u_regs (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                    .prdata, .pready, .cfg_o(cfg));
  dvrt_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
                      .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item));
  dvrt_engine #(.RouteDepth(RouteDepth), .NbDepth(NbDepth)) u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_item_i(q_item), .out_valid_o, .out_ready_i, .out_res_o(res));

  assign status_o = res.status;
  assign dest_id_res_o = res.dest;
  assign distance_o = res.distance;
  assign next_hop_o = res.hop;
  assign reachable_o = res.reach;
  assign down_count_o = res.down;
  assign message_done_o = res.done;
  assign last_o = res.last;
endmodule

@@ tb/sv/distance_vector_route_table_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table_chk
// Watches the item, result and register ports of the route table, keeps its
// own copy of the neighbor and route tables, and checks every result beat
// in order against the expected beats.
// ----------------------------------------------------------------------------
module distance_vector_route_table_chk
  import dvrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  src_id_i,
  input  logic [7:0]  dest_id_i,
  input  logic [15:0] value_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  status_i,
  input  logic [7:0]  dest_id_res_i,
  input  logic [15:0] distance_i,
  input  logic [7:0]  next_hop_i,
  input  logic        reachable_i,
  input  logic [4:0]  down_count_i,
  input  logic        message_done_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          beats_in_o,
  output int          beats_out_o
);
  localparam int Routes = RouteDepthDef;
  localparam int Nbs = NbDepthDef;

  cfg_t        cfg;
  logic [7:0]  rt_dest  [Routes];
  logic [15:0] rt_dist  [Routes];
  logic [7:0]  rt_hop   [Routes];
  logic        rt_reach [Routes];
  int          rt_count;
  logic [7:0]  nb_id    [Nbs];
  logic [15:0] nb_cost  [Nbs];
  logic        nb_heard [Nbs];
  logic        nb_down  [Nbs];
  logic [15:0] nb_age   [Nbs];
  int          nb_count;

  result_t     route_beats_q[$];

  function automatic logic [15:0] sum_sat(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void push_beat(input logic [3:0] st, input logic [7:0] d,
                                    input logic [15:0] dv, input logic [7:0] h,
                                    input logic r, input logic [4:0] dn,
                                    input logic dm, input logic l);
    result_t b;
    b.status = st; b.dest = d; b.distance = dv; b.hop = h;
    b.reach = r; b.down = dn; b.done = dm; b.last = l;
    route_beats_q.push_back(b);
  endfunction

  function automatic void push_route(input logic [3:0] st, input int r, input logic dm);
    push_beat(st, rt_dest[r], rt_dist[r], rt_hop[r], rt_reach[r], 5'd0, dm, 1'b1);
  endfunction

  function automatic void table_reset();
    cfg.self_id = 8'd0;
    cfg.limit = 16'd256;
    cfg.max_ticks = 16'd1000;
    cfg.enabled = 1'b1;
    for (int i = 0; i < Routes; i++) begin
      rt_dest[i] = '0; rt_dist[i] = '0; rt_hop[i] = '0; rt_reach[i] = 1'b0;
    end
    for (int i = 0; i < Nbs; i++) begin
      nb_id[i] = '0; nb_cost[i] = '0; nb_heard[i] = 1'b0; nb_down[i] = 1'b0;
      nb_age[i] = '0;
    end
    rt_dest[0] = 8'd0; rt_hop[0] = 8'd0; rt_reach[0] = 1'b1;
    rt_count = 1;
    nb_count = 0;
  endfunction

  function automatic void reg_write(input logic [1:0] idx, input logic [31:0] v);
    case (idx)
      RegSelf: begin
        cfg.self_id = v[7:0];
        rt_dest[0] = v[7:0]; rt_dist[0] = '0; rt_hop[0] = v[7:0]; rt_reach[0] = 1'b1;
      end
      RegLimit: cfg.limit = v[15:0];
      RegTicks: cfg.max_ticks = v[15:0];
      default: cfg.enabled = v[0];
    endcase
  endfunction

  function automatic int nb_lookup(input logic [7:0] id);
    for (int i = 0; i < nb_count; i++)
      if (nb_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int route_lookup(input logic [7:0] id);
    for (int i = 0; i < rt_count; i++)
      if (rt_dest[i] == id) return i;
    return -1;
  endfunction

  function automatic void route_step(input item_t it);
    int n;
    int r;
    int downs;
    logic [15:0] new_dist;
    logic [15:0] poison;
    logic [3:0] st;
    int lastk;
    case (it.cmd)
      CmdAddNb: begin
        n = nb_lookup(it.src_id);
        if (n < 0 && nb_count >= Nbs) begin
          push_beat(StNbFull, it.src_id, it.value, it.src_id, 1'b0, 5'd0, 1'b0, 1'b1);
        end else begin
          if (n < 0) begin
            n = nb_count++;
            nb_id[n] = it.src_id; nb_heard[n] = 1'b0; nb_down[n] = 1'b0; nb_age[n] = '0;
          end
          nb_cost[n] = it.value;
          push_beat(StNbAdded, it.src_id, it.value, it.src_id, 1'b0, 5'd0, 1'b0, 1'b1);
        end
      end
      CmdVector: begin
        n = nb_lookup(it.src_id);
        if (!cfg.enabled) begin
          push_beat(StDisabled, it.dest_id, '0, '0, 1'b0, 5'd0, it.eom, 1'b1);
        end else if (n < 0) begin
          push_beat(StUnknown, it.dest_id, '0, '0, 1'b0, 5'd0, it.eom, 1'b1);
        end else begin
          nb_heard[n] = 1'b1; nb_down[n] = 1'b0; nb_age[n] = '0;
          if (it.dest_id == cfg.self_id) begin
            push_route(StSelf, 0, it.eom);
          end else begin
            new_dist = sum_sat(it.value, nb_cost[n]);
            r = route_lookup(it.dest_id);
            if (r < 0) begin
              if (rt_count >= Routes) begin
                push_beat(StFull, it.dest_id, '0, '0, 1'b0, 5'd0, it.eom, 1'b1);
              end else begin
                r = rt_count++;
                rt_dest[r] = it.dest_id; rt_dist[r] = new_dist;
                rt_hop[r] = it.src_id; rt_reach[r] = 1'b1;
                push_route(StInsert, r, it.eom);
              end
            end else if (rt_dist[r] > new_dist) begin
              rt_dist[r] = new_dist; rt_hop[r] = it.src_id; rt_reach[r] = 1'b1;
              push_route(StImprove, r, it.eom);
            end else if (rt_hop[r] == it.src_id && rt_dist[r] != new_dist) begin
              st = StSameHop;
              rt_dist[r] = new_dist;
              if (new_dist >= cfg.limit) begin
                rt_reach[r] = 1'b0;
                st = StUnreach;
              end
              push_route(st, r, it.eom);
            end else begin
              push_route(StUnchanged, r, it.eom);
            end
          end
        end
      end
      CmdTick: begin
        downs = 0;
        poison = sum_sat(cfg.limit, 16'd16);
        for (int i = 0; i < nb_count; i++) begin
          if (nb_heard[i] && !nb_down[i]) begin
            if (nb_age[i] != 16'hFFFF) nb_age[i]++;
            if (nb_age[i] > cfg.max_ticks) begin
              nb_down[i] = 1'b1;
              if (downs < 31) downs++;
              for (int j = 1; j < rt_count; j++)
                if (rt_hop[j] == nb_id[i]) rt_dist[j] = poison;
            end
          end
        end
        push_beat(StTick, '0, '0, '0, 1'b0, 5'(downs), 1'b0, 1'b1);
      end
      default: begin
        if (!cfg.enabled) begin
          push_beat(StDisabled, '0, '0, '0, 1'b0, 5'd0, 1'b0, 1'b1);
        end else begin
          lastk = -1;
          for (int j = 0; j < rt_count; j++)
            if (rt_reach[j]) lastk = j;
          for (int j = 0; j < rt_count; j++)
            if (rt_reach[j])
              push_beat(StDump, rt_dest[j], rt_dist[j], rt_hop[j], 1'b1, 5'd0, 1'b0,
                        j == lastk);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t exp_b;
    if (!rst_ni) begin
      table_reset();
      route_beats_q.delete();
      fail_count_o = 0;
      beats_in_o = 0;
      beats_out_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) reg_write(paddr[3:2], pwdata);
      if (in_valid_i && in_ready_i) begin
        it.cmd = cmd_i; it.src_id = src_id_i; it.dest_id = dest_id_i;
        it.value = value_i; it.eom = end_of_message_i;
        route_step(it);
        beats_in_o++;
      end
      if (out_valid_i && out_ready_i) begin
        beats_out_o++;
        if (route_beats_q.size() == 0) begin
          $display("[%0t] result beat with nothing expected, status %0d", $time, status_i);
          fail_count_o++;
        end else begin
          exp_b = route_beats_q.pop_front();
          if (status_i !== exp_b.status)
            report_mismatch("status", int'(status_i), int'(exp_b.status));
          if (dest_id_res_i !== exp_b.dest)
            report_mismatch("dest_id_res", int'(dest_id_res_i), int'(exp_b.dest));
          if (distance_i !== exp_b.distance)
            report_mismatch("distance", int'(distance_i), int'(exp_b.distance));
          if (next_hop_i !== exp_b.hop)
            report_mismatch("next_hop", int'(next_hop_i), int'(exp_b.hop));
          if (reachable_i !== exp_b.reach)
            report_mismatch("reachable", int'(reachable_i), int'(exp_b.reach));
          if (down_count_i !== exp_b.down)
            report_mismatch("down_count", int'(down_count_i), int'(exp_b.down));
          if (message_done_i !== exp_b.done)
            report_mismatch("message_done", int'(message_done_i), int'(exp_b.done));
          if (last_i !== exp_b.last)
            report_mismatch("last", int'(last_i), int'(exp_b.last));
        end
      end
    end
    pending_o = route_beats_q.size();
  end
endmodule

@@ tb/sv/distance_vector_route_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table_tb
// Drives neighbor adds, vector entries, ticks and dumps through several
// register settings with random gaps and output stalls; the checker module
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module distance_vector_route_table_tb;
  import dvrt_pkg::*;

  localparam int CycleLimit = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [7:0]  src_id_i = '0, dest_id_i = '0;
  logic [15:0] value_i = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  status_o;
  logic [7:0]  dest_id_res_o, next_hop_o;
  logic [15:0] distance_o;
  logic        reachable_o, message_done_o, last_o;
  logic [4:0]  down_count_o;

  int   fail_count, pending, beats_in, beats_out, cycles;
  logic in_taken;
  logic no_idle = 1'b0;
  logic [7:0] nb_pool[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  distance_vector_route_table u_dut (.*);

  distance_vector_route_table_chk u_chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .src_id_i, .dest_id_i, .value_i,
    .end_of_message_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .dest_id_res_i(dest_id_res_o), .distance_i(distance_o),
    .next_hop_i(next_hop_o), .reachable_i(reachable_o), .down_count_i(down_count_o),
    .message_done_i(message_done_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .beats_in_o(beats_in),
    .beats_out_o(beats_out)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** distance_vector_route_table: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic [1:0] c, input logic [7:0] s, input logic [7:0] d,
                           input logic [15:0] v, input logic e);
    if (!no_idle && $urandom_range(99) < 33) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = c; src_id_i = s; dest_id_i = d; value_i = v; end_of_message_i = e;
    do @(negedge clk_i); while (!in_taken);
    in_valid_i = 1'b0;
    if (c == CmdAddNb) nb_pool.push_back(s);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(400));
    endcase
  endfunction

  task automatic random_beats(input int count);
    logic [1:0] c;
    logic [7:0] s, d;
    int w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(99);
      if (w < 12) c = CmdAddNb;
      else if (w < 77) c = CmdVector;
      else if (w < 91) c = CmdTick;
      else c = CmdDump;
      if (nb_pool.size() != 0 && $urandom_range(9) < 8)
        s = nb_pool[$urandom_range(nb_pool.size() - 1)];
      else
        s = 8'($urandom_range(255));
      d = ($urandom_range(1)) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
      send_beat(c, s, d, pick_value(), 1'($urandom_range(1)));
      if (i == count / 2 && $urandom_range(1)) begin
        while (pending != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: unknown sender, adds, self, insert, improve, same hop, unreachable
    send_beat(CmdVector, 8'd5, 8'd10, 16'd32, 1'b0);
    send_beat(CmdAddNb, 8'h00, 8'd0, 16'd0, 1'b0);
    send_beat(CmdAddNb, 8'hFF, 8'd0, 16'hFFFF, 1'b0);
    send_beat(CmdAddNb, 8'd5, 8'd0, 16'd16, 1'b0);
    send_beat(CmdVector, 8'd5, 8'd0, 16'd7, 1'b0);
    send_beat(CmdVector, 8'd5, 8'd10, 16'd32, 1'b0);
    send_beat(CmdVector, 8'd5, 8'd10, 16'd16, 1'b0);
    send_beat(CmdVector, 8'd5, 8'd10, 16'd300, 1'b0);
    send_beat(CmdVector, 8'hFF, 8'd10, 16'hFFFF, 1'b0);
    send_beat(CmdVector, 8'hFF, 8'hAA, 16'hFFFF, 1'b0);
    send_beat(CmdVector, 8'h00, 8'h55, 16'd0, 1'b1);
    send_beat(CmdAddNb, 8'd5, 8'd0, 16'd0, 1'b0);
    send_beat(CmdVector, 8'd5, 8'd10, 16'd3, 1'b1);
    send_beat(CmdDump, 8'd0, 8'd0, 16'd0, 1'b0);
    send_beat(CmdTick, 8'd0, 8'd0, 16'd0, 1'b0);
    drain();

    // quick aging and a zero limit
    reg_write(RegTicks, 32'd1);
    reg_write(RegLimit, 32'd0);
    send_beat(CmdTick, 8'd0, 8'd0, 16'd0, 1'b0);
    send_beat(CmdTick, 8'd0, 8'd0, 16'd0, 1'b0);
    send_beat(CmdDump, 8'd0, 8'd0, 16'd0, 1'b0);
    no_idle = 1'b1;
    random_beats(20);
    no_idle = 1'b0;
    drain();

    // fill neighbor and route tables
    reg_write(RegLimit, 32'hFFFF);
    reg_write(RegTicks, 32'hFFFF);
    reg_write(RegSelf, 32'hFF);
    for (int i = 0; i < 18; i++)
      send_beat(CmdAddNb, 8'($urandom_range(255)), 8'd0, pick_value(), 1'b0);
    for (int i = 0; i < 66; i++)
      send_beat(CmdVector, 8'd5, 8'(i), pick_value(), 1'($urandom_range(1)));
    send_beat(CmdDump, 8'd0, 8'd0, 16'd0, 1'b0);
    drain();

    // disabled node
    reg_write(RegEnable, 32'd0);
    random_beats(10);
    drain();

    reg_write(RegEnable, 32'd1);
    reg_write(RegSelf, 32'd3);
    reg_write(RegLimit, 32'd256);
    reg_write(RegTicks, 32'd2);
    random_beats(20);
    drain();

    $display("Covered %0d input beats and %0d result beats over five register settings",
             beats_in, beats_out);
    $display("including full tables, aging to down, disabled node and saturating costs.");
    if (fail_count == 0) begin
      $display("** distance_vector_route_table: PASSED **");
    end else begin
      $display("** distance_vector_route_table: FAILED **");
    end
    $finish;
  end
endmodule

@@ distance_vector_route_table.f @@
+incdir+hdl
hdl/dvrt_pkg.sv
hdl/dvrt_front.sv
hdl/dvrt_engine.sv
hdl/dvrt_regs.sv
hdl/distance_vector_route_table.sv
tb/sv/distance_vector_route_table_chk.sv
tb/sv/distance_vector_route_table_tb.sv
